// File: design/led_pkg.sv
// Shared types, constants and helpers for the luma edge deblocking filter.
// Used by the channel interfaces, every module of the block and the checker.
package led_pkg;

  localparam int SAMPLE_W          = 14;
  localparam int STRENGTH_W        = 3;
  localparam int RAW_W             = 8;
  localparam int DEPTH_W           = 4;
  localparam int DEPTH_MIN         = 8;
  localparam int MAX_DEPTH_DEFAULT = 14;

  localparam logic [DEPTH_W-1:0]    DEPTH_RESET = DEPTH_W'(8);
  localparam logic [STRENGTH_W-1:0] BS_OFF      = STRENGTH_W'(0);
  localparam logic [STRENGTH_W-1:0] BS_STRONG   = STRENGTH_W'(4);

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t p3;
    sample_t p2;
    sample_t p1;
    sample_t p0;
    sample_t q0;
    sample_t q1;
    sample_t q2;
    sample_t q3;
  } line_t;

  // Decisions taken for one line, handed from the decision logic to the filter.
  typedef struct packed {
    logic on;
    logic strong_sel;
    logic full;
    logic ap;
    logic aq;
  } ctrl_t;

  typedef struct packed {
    sample_t p2;
    sample_t p1;
    sample_t p0;
    sample_t q0;
    sample_t q1;
    sample_t q2;
    logic    filtered;
  } res_t;

  function automatic sample_t absd(sample_t a, sample_t b);
    sample_t r;
    if (a > b) begin
      r = a - b;
    end else begin
      r = b - a;
    end
    return r;
  endfunction

endpackage

// File: design/led_if.sv
// Valid/ready channel interfaces for the deblocking filter's input and result words.
// Depends on led_pkg for the sample and field widths.
interface led_in_if;
  import led_pkg::*;

  logic                  valid;
  logic                  ready;
  sample_t               p3_in;
  sample_t               p2_in;
  sample_t               p1_in;
  sample_t               p0_in;
  sample_t               q0_in;
  sample_t               q1_in;
  sample_t               q2_in;
  sample_t               q3_in;
  logic [STRENGTH_W-1:0] strength;
  logic [RAW_W-1:0]      alpha_raw;
  logic [RAW_W-1:0]      beta_raw;
  logic [RAW_W-1:0]      tc0_raw;

  modport source (
    output valid, p3_in, p2_in, p1_in, p0_in, q0_in, q1_in, q2_in, q3_in,
           strength, alpha_raw, beta_raw, tc0_raw,
    input  ready
  );

  modport sink (
    input  valid, p3_in, p2_in, p1_in, p0_in, q0_in, q1_in, q2_in, q3_in,
           strength, alpha_raw, beta_raw, tc0_raw,
    output ready
  );
endinterface

interface led_out_if;
  import led_pkg::*;

  logic    valid;
  logic    ready;
  sample_t p2_out;
  sample_t p1_out;
  sample_t p0_out;
  sample_t q0_out;
  sample_t q1_out;
  sample_t q2_out;
  logic    was_filtered;

  modport source (
    output valid, p2_out, p1_out, p0_out, q0_out, q1_out, q2_out, was_filtered,
    input  ready
  );

  modport sink (
    input  valid, p2_out, p1_out, p0_out, q0_out, q1_out, q2_out, was_filtered,
    output ready
  );
endinterface

// File: design/luma_edge_deblock_filter.sv
// Top level of the luma edge deblocking filter: channel registers and configuration.
// Depends on led_pkg, led_if, led_decide and led_filter.
//
// The block filters one line of eight luma samples across a block edge per clock cycle
// while the output does not stall. A word accepted on the input channel is held in an
// input register, passes through the combinational decision and filter logic and is
// captured in the result register, from which it is offered on the output; a new line
// may be accepted every cycle unless the output stalls.
// The result register frees the input side whenever its word is taken or it is empty, so
// a stall on the output holds both stages and releases them together. The bit depth
// register must only be written while no line is in flight; depths outside 8 to the
// configured maximum saturate to that range.
module luma_edge_deblock_filter #(
  parameter int MAX_DEPTH = led_pkg::MAX_DEPTH_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [led_pkg::DEPTH_W-1:0]  cfg_wdata_i,
  led_in_if.sink                       in_i,
  led_out_if.source                    out_o
);
  import led_pkg::*;

  logic [DEPTH_W-1:0]    depth_q;
  logic                  s1_valid_q, s1_valid_d;
  line_t                 line_q;
  logic [STRENGTH_W-1:0] strength_q;
  logic [RAW_W-1:0]      alpha_q;
  logic [RAW_W-1:0]      beta_q;
  logic [RAW_W-1:0]      tc0_q;
  logic                  out_valid_q, out_valid_d;
  res_t                  res_q;

  logic                  advance;
  logic                  in_take;
  ctrl_t                 ctrl;
  logic [MAX_DEPTH-1:0]  tc0;
  logic [MAX_DEPTH:0]    tc;
  logic [MAX_DEPTH-1:0]  maxv;
  res_t                  res;

  assign advance   = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || advance;
  assign in_take   = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (in_i.ready) begin
      s1_valid_d = in_i.valid;
    end
    if (advance) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= DEPTH_RESET;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        depth_q <= cfg_wdata_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      line_q.p3  <= in_i.p3_in;
      line_q.p2  <= in_i.p2_in;
      line_q.p1  <= in_i.p1_in;
      line_q.p0  <= in_i.p0_in;
      line_q.q0  <= in_i.q0_in;
      line_q.q1  <= in_i.q1_in;
      line_q.q2  <= in_i.q2_in;
      line_q.q3  <= in_i.q3_in;
      strength_q <= in_i.strength;
      alpha_q    <= in_i.alpha_raw;
      beta_q     <= in_i.beta_raw;
      tc0_q      <= in_i.tc0_raw;
    end
    if (advance && s1_valid_q) begin
      res_q <= res;
    end
  end

  led_decide #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_decide (
    .line_i      (line_q),
    .strength_i  (strength_q),
    .alpha_raw_i (alpha_q),
    .beta_raw_i  (beta_q),
    .tc0_raw_i   (tc0_q),
    .depth_i     (depth_q),
    .ctrl_o      (ctrl),
    .tc0_o       (tc0),
    .tc_o        (tc),
    .maxv_o      (maxv)
  );

  led_filter #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_filter (
    .line_i (line_q),
    .ctrl_i (ctrl),
    .tc0_i  (tc0),
    .tc_i   (tc),
    .maxv_i (maxv),
    .res_o  (res)
  );

  assign out_o.valid        = out_valid_q;
  assign out_o.p2_out       = res_q.p2;
  assign out_o.p1_out       = res_q.p1;
  assign out_o.p0_out       = res_q.p0;
  assign out_o.q0_out       = res_q.q0;
  assign out_o.q1_out       = res_q.q1;
  assign out_o.q2_out       = res_q.q2;
  assign out_o.was_filtered = res_q.filtered;

endmodule

// File: design/led_decide.sv
// Threshold scaling and filter decisions for one registered line of samples.
// Depends on led_pkg; feeds led_filter.
module led_decide #(
  parameter int MAX_DEPTH = led_pkg::MAX_DEPTH_DEFAULT
) (
  input  led_pkg::line_t                  line_i,
  input  logic [led_pkg::STRENGTH_W-1:0]  strength_i,
  input  logic [led_pkg::RAW_W-1:0]       alpha_raw_i,
  input  logic [led_pkg::RAW_W-1:0]       beta_raw_i,
  input  logic [led_pkg::RAW_W-1:0]       tc0_raw_i,
  input  logic [led_pkg::DEPTH_W-1:0]     depth_i,
  output led_pkg::ctrl_t                  ctrl_o,
  output logic [MAX_DEPTH-1:0]            tc0_o,
  output logic [MAX_DEPTH:0]              tc_o,
  output logic [MAX_DEPTH-1:0]            maxv_o
);
  import led_pkg::*;

  localparam int TH_W = RAW_W + MAX_DEPTH - DEPTH_MIN;
  localparam int SH_W = $clog2(MAX_DEPTH - DEPTH_MIN + 2);
  localparam int CW   = ((TH_W > SAMPLE_W) ? TH_W : SAMPLE_W) + 1;

  logic [DEPTH_W:0]  dep_x;
  logic [SH_W-1:0]   sh;
  logic [TH_W-1:0]   alpha_s;
  logic [TH_W-1:0]   beta_s;
  logic [TH_W-1:0]   tc0_s;
  sample_t           a_pq;
  sample_t           a_p1;
  sample_t           a_q1;
  sample_t           a_p2;
  sample_t           a_q2;
  logic              ap;
  logic              aq;

  always_comb begin
    dep_x = {1'b0, depth_i};
    if (dep_x < (DEPTH_W+1)'(DEPTH_MIN)) begin
      sh = '0;
    end else if (dep_x > (DEPTH_W+1)'(MAX_DEPTH)) begin
      sh = SH_W'(MAX_DEPTH - DEPTH_MIN);
    end else begin
      sh = SH_W'(dep_x - (DEPTH_W+1)'(DEPTH_MIN));
    end
  end

  assign alpha_s = TH_W'(alpha_raw_i) << sh;
  assign beta_s  = TH_W'(beta_raw_i) << sh;
  assign tc0_s   = TH_W'(tc0_raw_i) << sh;
  assign maxv_o  = ~({MAX_DEPTH{1'b1}} << (SH_W + 4)'(DEPTH_MIN + int'(sh)));

  assign a_pq = absd(line_i.p0, line_i.q0);
  assign a_p1 = absd(line_i.p1, line_i.p0);
  assign a_q1 = absd(line_i.q1, line_i.q0);
  assign a_p2 = absd(line_i.p2, line_i.p0);
  assign a_q2 = absd(line_i.q2, line_i.q0);

  assign ap = CW'(a_p2) < CW'(beta_s);
  assign aq = CW'(a_q2) < CW'(beta_s);

  always_comb begin
    ctrl_o.on = (strength_i != BS_OFF) && (CW'(a_pq) < CW'(alpha_s)) &&
                (CW'(a_p1) < CW'(beta_s)) && (CW'(a_q1) < CW'(beta_s));
    ctrl_o.strong_sel = strength_i == BS_STRONG;
    ctrl_o.full       = CW'(a_pq) < (CW'(alpha_s >> 2) + CW'(2));
    ctrl_o.ap         = ap;
    ctrl_o.aq         = aq;
  end

  assign tc0_o = tc0_s;
  assign tc_o  = (TH_W+1)'(tc0_s) + (TH_W+1)'(ap) + (TH_W+1)'(aq);

endmodule

// File: design/led_filter.sv
// Strong and weak luma filter arithmetic for one line, selected by the decisions.
// Depends on led_pkg and on the outputs of led_decide.
module led_filter #(
  parameter int MAX_DEPTH = led_pkg::MAX_DEPTH_DEFAULT
) (
  input  led_pkg::line_t        line_i,
  input  led_pkg::ctrl_t        ctrl_i,
  input  logic [MAX_DEPTH-1:0]  tc0_i,
  input  logic [MAX_DEPTH:0]    tc_i,
  input  logic [MAX_DEPTH-1:0]  maxv_i,
  output led_pkg::res_t         res_o
);
  import led_pkg::*;

  localparam int W = ((MAX_DEPTH > SAMPLE_W) ? MAX_DEPTH : SAMPLE_W) + 6;

  function automatic logic signed [W-1:0] sx(sample_t v);
    return $signed({{(W-SAMPLE_W){1'b0}}, v});
  endfunction

  function automatic logic signed [W-1:0] clip_sym(logic signed [W-1:0] x,
                                                   logic signed [W-1:0] lim);
    logic signed [W-1:0] r;
    if (x > lim) begin
      r = lim;
    end else if (x < -lim) begin
      r = -lim;
    end else begin
      r = x;
    end
    return r;
  endfunction

  function automatic logic signed [W-1:0] clamp_range(logic signed [W-1:0] x,
                                                      logic signed [W-1:0] maxv);
    logic signed [W-1:0] r;
    if (x > maxv) begin
      r = maxv;
    end else if (x < W'(0)) begin
      r = W'(0);
    end else begin
      r = x;
    end
    return r;
  endfunction

  logic signed [W-1:0] p3, p2, p1, p0, q0, q1, q2, q3;
  logic signed [W-1:0] tc0, tc, maxv;
  logic signed [W-1:0] tp, tq;
  logic signed [W-1:0] sp0, sp1, sp2, sq0, sq1, sq2, sp0b, sq0b;
  logic signed [W-1:0] d, dc, avg, wp0, wq0, wp1, wq1;
  logic signed [W-1:0] np2, np1, np0, nq0, nq1, nq2;

  always_comb begin
    p3   = sx(line_i.p3);
    p2   = sx(line_i.p2);
    p1   = sx(line_i.p1);
    p0   = sx(line_i.p0);
    q0   = sx(line_i.q0);
    q1   = sx(line_i.q1);
    q2   = sx(line_i.q2);
    q3   = sx(line_i.q3);
    tc0  = $signed(W'(tc0_i));
    tc   = $signed(W'(tc_i));
    maxv = $signed(W'(maxv_i));
  end

  // Strong filter, three-sample form and one-sample (three-tap) form on each side.
  always_comb begin
    tp   = p1 + p0 + q0;
    tq   = q1 + q0 + p0;
    sp0  = (p2 + (tp <<< 1) + q1 + W'(4)) >>> 3;
    sp1  = (p2 + tp + W'(2)) >>> 2;
    sp2  = ((p3 <<< 1) + (p2 <<< 1) + p2 + tp + W'(4)) >>> 3;
    sq0  = (q2 + (tq <<< 1) + p1 + W'(4)) >>> 3;
    sq1  = (q2 + tq + W'(2)) >>> 2;
    sq2  = ((q3 <<< 1) + (q2 <<< 1) + q2 + tq + W'(4)) >>> 3;
    sp0b = ((p1 <<< 1) + p0 + q1 + W'(2)) >>> 2;
    sq0b = ((q1 <<< 1) + q0 + p1 + W'(2)) >>> 2;
  end

  // Weak filter; the edge pair is only touched when the raw delta is nonzero.
  always_comb begin
    d   = (((q0 - p0) <<< 2) + (p1 - q1) + W'(4)) >>> 3;
    avg = (p0 + q0 + W'(1)) >>> 1;
    dc  = clip_sym(d, tc);
    if (d != W'(0)) begin
      wp0 = clamp_range(p0 + dc, maxv);
      wq0 = clamp_range(q0 - dc, maxv);
    end else begin
      wp0 = p0;
      wq0 = q0;
    end
    wp1 = p1 + clip_sym((p2 + avg - (p1 <<< 1)) >>> 1, tc0);
    wq1 = q1 + clip_sym((q2 + avg - (q1 <<< 1)) >>> 1, tc0);
  end

  always_comb begin
    np2 = p2;
    np1 = p1;
    np0 = p0;
    nq0 = q0;
    nq1 = q1;
    nq2 = q2;
    if (ctrl_i.on) begin
      if (ctrl_i.strong_sel) begin
        if (ctrl_i.full && ctrl_i.ap) begin
          np0 = sp0;
          np1 = sp1;
          np2 = sp2;
        end else begin
          np0 = sp0b;
        end
        if (ctrl_i.full && ctrl_i.aq) begin
          nq0 = sq0;
          nq1 = sq1;
          nq2 = sq2;
        end else begin
          nq0 = sq0b;
        end
      end else begin
        np0 = wp0;
        nq0 = wq0;
        if (ctrl_i.ap) begin
          np1 = wp1;
        end
        if (ctrl_i.aq) begin
          nq1 = wq1;
        end
      end
    end
  end

  always_comb begin
    res_o.p2       = np2[SAMPLE_W-1:0];
    res_o.p1       = np1[SAMPLE_W-1:0];
    res_o.p0       = np0[SAMPLE_W-1:0];
    res_o.q0       = nq0[SAMPLE_W-1:0];
    res_o.q1       = nq1[SAMPLE_W-1:0];
    res_o.q2       = nq2[SAMPLE_W-1:0];
    res_o.filtered = ctrl_i.on;
  end

endmodule

// File: design/led_checker.sv
// Port-level assertions for the luma edge deblocking filter and their bind statement.
// Depends on led_pkg and attaches to luma_edge_deblock_filter.
module led_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [6*led_pkg::SAMPLE_W:0]      out_word_i
);
  import led_pkg::*;

  // A result word that is stalled stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i))
    else $error("result word changed or dropped while stalled");

  // With no result waiting, the input side is always open.
  a_in_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input refused while the result register is empty");

  // An accepted line is offered if the output is ready in the cycle after acceptance.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) ##1 out_ready_i |=> out_valid_i)
    else $error("accepted line did not appear on the output");

endmodule

bind luma_edge_deblock_filter led_checker u_led_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_word_i  ({out_o.p2_out, out_o.p1_out, out_o.p0_out, out_o.q0_out,
                 out_o.q1_out, out_o.q2_out, out_o.was_filtered})
);

// File: dv/tb_luma_edge_deblock_filter.sv
// Self-checking bench for luma_edge_deblock_filter: edge lines in, filtered samples out.
// Depends on led_pkg and the led_in_if / led_out_if channel interfaces of the design.
`timescale 1ns / 1ps

module tb_luma_edge_deblock_filter;
  import led_pkg::*;

  typedef struct packed {
    line_t                 samples;
    logic [STRENGTH_W-1:0] bs;
    logic [RAW_W-1:0]      alpha;
    logic [RAW_W-1:0]      beta;
    logic [RAW_W-1:0]      tc0;
  } edge_line_t;

  localparam int LINES_PER_DEPTH = 200;
  localparam int HOLD_AFTER      = 1300;
  localparam int HOLD_CYCLES     = 300;

  class filtered_lines;
    res_t                 pending_lines[$];
    logic [DEPTH_W-1:0]   depth_reg;
    int unsigned          mismatches;

    function new();
      depth_reg  = DEPTH_RESET;
      mismatches = 0;
    endfunction

    function int eff_depth();
      if (depth_reg < DEPTH_MIN) begin
        return DEPTH_MIN;
      end
      if (depth_reg > MAX_DEPTH_DEFAULT) begin
        return MAX_DEPTH_DEFAULT;
      end
      return int'(depth_reg);
    endfunction

    function int gap(int a, int b);
      return (a > b) ? a - b : b - a;
    endfunction

    function int clip(int x, int lim);
      if (x > lim) begin
        return lim;
      end
      if (x < -lim) begin
        return -lim;
      end
      return x;
    endfunction

    function int clamp(int x, int top);
      if (x > top) begin
        return top;
      end
      if (x < 0) begin
        return 0;
      end
      return x;
    endfunction

    function res_t filter_line(edge_line_t ln);
      int   p3, p2, p1, p0, q0, q1, q2, q3;
      int   depth, alpha, beta, tc0, tc, top, edge_step, delta, avg, sum;
      int   np2, np1, np0, nq0, nq1, nq2;
      bit   on, ap, aq, full;
      res_t r;
      p3 = int'(ln.samples.p3);
      p2 = int'(ln.samples.p2);
      p1 = int'(ln.samples.p1);
      p0 = int'(ln.samples.p0);
      q0 = int'(ln.samples.q0);
      q1 = int'(ln.samples.q1);
      q2 = int'(ln.samples.q2);
      q3 = int'(ln.samples.q3);
      depth = eff_depth();
      alpha = int'(ln.alpha) << (depth - DEPTH_MIN);
      beta  = int'(ln.beta) << (depth - DEPTH_MIN);
      tc0   = int'(ln.tc0) << (depth - DEPTH_MIN);
      top   = (1 << depth) - 1;
      np2 = p2;
      np1 = p1;
      np0 = p0;
      nq0 = q0;
      nq1 = q1;
      nq2 = q2;
      edge_step = gap(p0, q0);
      on = (ln.bs != BS_OFF) && (edge_step < alpha) && (gap(p1, p0) < beta) &&
           (gap(q1, q0) < beta);
      if (on) begin
        ap = gap(p2, p0) < beta;
        aq = gap(q2, q0) < beta;
        if (ln.bs == BS_STRONG) begin
          full = edge_step < ((alpha >> 2) + 2);
          if (full && ap) begin
            sum = p1 + p0 + q0;
            np0 = (p2 + 2 * sum + q1 + 4) >> 3;
            np1 = (p2 + sum + 2) >> 2;
            np2 = (2 * p3 + 3 * p2 + sum + 4) >> 3;
          end else begin
            np0 = (2 * p1 + p0 + q1 + 2) >> 2;
          end
          if (full && aq) begin
            sum = q1 + q0 + p0;
            nq0 = (q2 + 2 * sum + p1 + 4) >> 3;
            nq1 = (q2 + sum + 2) >> 2;
            nq2 = (2 * q3 + 3 * q2 + sum + 4) >> 3;
          end else begin
            nq0 = (2 * q1 + q0 + p1 + 2) >> 2;
          end
        end else begin
          tc    = tc0 + int'(ap) + int'(aq);
          delta = ((q0 - p0) * 4 + (p1 - q1) + 4) >>> 3;
          avg   = (p0 + q0 + 1) >> 1;
          if (delta != 0) begin
            delta = clip(delta, tc);
            np0   = clamp(p0 + delta, top);
            nq0   = clamp(q0 - delta, top);
          end
          if (ap) begin
            np1 = p1 + clip((p2 + avg - 2 * p1) >>> 1, tc0);
          end
          if (aq) begin
            nq1 = q1 + clip((q2 + avg - 2 * q1) >>> 1, tc0);
          end
        end
      end
      r.p2       = sample_t'(np2);
      r.p1       = sample_t'(np1);
      r.p0       = sample_t'(np0);
      r.q0       = sample_t'(nq0);
      r.q1       = sample_t'(nq1);
      r.q2       = sample_t'(nq2);
      r.filtered = on;
      return r;
    endfunction

    function void note_line(edge_line_t ln);
      pending_lines.push_back(filter_line(ln));
    endfunction

    function int outstanding();
      return pending_lines.size();
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_line(res_t got);
      res_t want;
      if (pending_lines.size() == 0) begin
        mismatches++;
        $display("%0t: result word with no line outstanding, expected none, got %h",
                 $time, got);
        return;
      end
      want = pending_lines.pop_front();
      check_field("p2_out", want.p2, got.p2);
      check_field("p1_out", want.p1, got.p1);
      check_field("p0_out", want.p0, got.p0);
      check_field("q0_out", want.q0, got.q0);
      check_field("q1_out", want.q1, got.q1);
      check_field("q2_out", want.q2, got.q2);
      check_field("was_filtered", want.filtered, got.filtered);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i;
  logic [DEPTH_W-1:0] cfg_wdata_i;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  filtered_lines      book;

  led_in_if  in_ch ();
  led_out_if out_ch ();

  luma_edge_deblock_filter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic edge_line_t make_line(int p3, int p2, int p1, int p0, int q0, int q1,
                                           int q2, int q3, int bs, int alpha, int beta,
                                           int tc0);
    edge_line_t ln;
    ln.samples.p3 = sample_t'(p3);
    ln.samples.p2 = sample_t'(p2);
    ln.samples.p1 = sample_t'(p1);
    ln.samples.p0 = sample_t'(p0);
    ln.samples.q0 = sample_t'(q0);
    ln.samples.q1 = sample_t'(q1);
    ln.samples.q2 = sample_t'(q2);
    ln.samples.q3 = sample_t'(q3);
    ln.bs         = STRENGTH_W'(bs);
    ln.alpha      = RAW_W'(alpha);
    ln.beta       = RAW_W'(beta);
    ln.tc0        = RAW_W'(tc0);
    return ln;
  endfunction

  // Most lines are smooth around a common level so that the threshold checks pass and
  // every filter branch is reached; the rest are raw noise over the full field ranges.
  function automatic edge_line_t random_line();
    edge_line_t ln;
    int         s[8];
    int         depth, base, spread, step, i;
    depth = book.eff_depth();
    if ($urandom_range(99) < 35) begin
      ln.bs = BS_STRONG;
    end else begin
      ln.bs = STRENGTH_W'($urandom_range(0, 7));
    end
    ln.alpha = RAW_W'($urandom);
    ln.beta  = ($urandom_range(1) == 0) ? RAW_W'($urandom_range(0, 63)) : RAW_W'($urandom);
    ln.tc0   = ($urandom_range(1) == 0) ? RAW_W'($urandom_range(0, 15)) : RAW_W'($urandom);
    if ($urandom_range(99) < 25) begin
      for (i = 0; i < 8; i++) begin
        s[i] = $urandom_range(0, (1 << SAMPLE_W) - 1);
      end
    end else begin
      if ($urandom_range(9) == 0) begin
        base = $urandom_range(0, (1 << SAMPLE_W) - 1);
      end else begin
        base = $urandom_range(0, (1 << depth) - 1);
      end
      spread = $urandom_range(0, 24) << (depth - DEPTH_MIN);
      step   = int'($urandom_range(0, 4 * spread)) - 2 * spread;
      for (i = 0; i < 8; i++) begin
        s[i] = base + int'($urandom_range(0, 2 * spread)) - spread + ((i >= 4) ? step : 0);
        if (s[i] < 0) begin
          s[i] = 0;
        end else if (s[i] > (1 << SAMPLE_W) - 1) begin
          s[i] = (1 << SAMPLE_W) - 1;
        end
      end
    end
    ln.samples.p3 = sample_t'(s[0]);
    ln.samples.p2 = sample_t'(s[1]);
    ln.samples.p1 = sample_t'(s[2]);
    ln.samples.p0 = sample_t'(s[3]);
    ln.samples.q0 = sample_t'(s[4]);
    ln.samples.q1 = sample_t'(s[5]);
    ln.samples.q2 = sample_t'(s[6]);
    ln.samples.q3 = sample_t'(s[7]);
    return ln;
  endfunction

  task automatic send_line(input edge_line_t ln);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.p3_in     <= ln.samples.p3;
    in_ch.p2_in     <= ln.samples.p2;
    in_ch.p1_in     <= ln.samples.p1;
    in_ch.p0_in     <= ln.samples.p0;
    in_ch.q0_in     <= ln.samples.q0;
    in_ch.q1_in     <= ln.samples.q1;
    in_ch.q2_in     <= ln.samples.q2;
    in_ch.q3_in     <= ln.samples.q3;
    in_ch.strength  <= ln.bs;
    in_ch.alpha_raw <= ln.alpha;
    in_ch.beta_raw  <= ln.beta;
    in_ch.tc0_raw   <= ln.tc0;
    do begin
      @(posedge clk_i);
    end while (in_ch.ready !== 1'b1);
    book.note_line(ln);
  endtask

  task automatic drain_lines();
    in_ch.valid <= 1'b0;
    while (book.outstanding() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_depth(input int depth);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= DEPTH_W'(depth);
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    book.depth_reg = DEPTH_W'(depth);
  endtask

  // The receiver holds off once for a long stretch so that both stages fill and the
  // input stalls while the sender keeps offering words.
  initial begin : result_sink
    int   results_seen;
    int   hold_left;
    bit   held_once;
    res_t got;
    results_seen = 0;
    hold_left    = 0;
    held_once    = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.p2       = out_ch.p2_out;
        got.p1       = out_ch.p1_out;
        got.p0       = out_ch.p0_out;
        got.q0       = out_ch.q0_out;
        got.q1       = out_ch.q1_out;
        got.q2       = out_ch.q2_out;
        got.filtered = out_ch.was_filtered;
        book.check_line(got);
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!held_once && results_seen >= HOLD_AFTER) begin
        held_once    = 1'b1;
        hold_left    = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("tb_luma_edge_deblock_filter failed");
    $finish;
  end

  initial begin : stimulus
    int depth_plan[9];
    int phase, n;
    book            = new();
    depth_plan      = '{8, 14, 0, 15, 11, 9, 12, 10, 13};
    send_idle_pct   = 33;
    recv_idle_pct   = 87;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= DEPTH_RESET;
    in_ch.valid     <= 1'b0;
    in_ch.p3_in     <= '0;
    in_ch.p2_in     <= '0;
    in_ch.p1_in     <= '0;
    in_ch.p0_in     <= '0;
    in_ch.q0_in     <= '0;
    in_ch.q1_in     <= '0;
    in_ch.q2_in     <= '0;
    in_ch.q3_in     <= '0;
    in_ch.strength  <= BS_OFF;
    in_ch.alpha_raw <= '0;
    in_ch.beta_raw  <= '0;
    in_ch.tc0_raw   <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines at a depth of eight, where the clamp maximum is 255.
    write_depth(8);
    send_line(make_line(0, 0, 0, 0, 0, 0, 0, 0, BS_OFF, 255, 255, 255));
    send_line(make_line(16383, 16383, 16383, 16383, 16383, 16383, 16383, 16383,
                        BS_STRONG, 255, 255, 255));
    send_line(make_line(16383, 16383, 16383, 16383, 16383, 16383, 16383, 16383,
                        1, 255, 255, 255));
    send_line(make_line(60, 62, 64, 66, 70, 72, 74, 76, BS_STRONG, 40, 10, 0));
    send_line(make_line(60, 62, 64, 66, 90, 92, 94, 96, BS_STRONG, 40, 10, 0));
    send_line(make_line(60, 90, 64, 66, 70, 72, 74, 76, BS_STRONG, 40, 10, 0));
    send_line(make_line(60, 62, 64, 66, 80, 82, 84, 86, 1, 40, 10, 2));
    send_line(make_line(60, 62, 64, 66, 80, 82, 84, 86, 2, 40, 10, 0));
    send_line(make_line(60, 62, 64, 66, 80, 82, 84, 86, 3, 40, 10, 20));
    send_line(make_line(50, 50, 50, 50, 50, 50, 50, 50, 2, 40, 10, 5));
    send_line(make_line(0, 0, 40, 0, 2, 0, 0, 0, 3, 255, 255, 255));
    send_line(make_line(0, 300, 300, 300, 280, 280, 280, 0, 1, 255, 255, 255));
    send_line(make_line(60, 62, 64, 66, 80, 82, 84, 86, 5, 40, 10, 2));
    send_line(make_line(60, 62, 64, 66, 80, 82, 84, 86, 6, 40, 10, 2));
    send_line(make_line(60, 62, 64, 66, 80, 82, 84, 86, 7, 40, 10, 2));
    send_line(make_line(60, 62, 64, 66, 70, 72, 74, 76, BS_STRONG, 0, 10, 0));
    send_line(make_line(60, 62, 64, 66, 70, 72, 74, 76, BS_STRONG, 40, 0, 0));
    send_line(make_line(60, 62, 64, 64, 74, 72, 74, 76, 1, 10, 10, 3));
    send_line(make_line(60, 62, 64, 64, 74, 72, 74, 76, 1, 11, 10, 3));
    send_line(make_line(60, 62, 74, 64, 66, 68, 70, 72, 2, 40, 10, 3));
    send_line(make_line(60, 100, 64, 66, 70, 72, 74, 76, 2, 40, 10, 3));
    send_line(make_line(0, 0, 0, 0, 200, 200, 200, 200, 1, 255, 255, 255));
    send_line(make_line(16383, 0, 16383, 0, 16383, 0, 16383, 0, BS_STRONG, 255, 255, 255));
    drain_lines();

    for (phase = 0; phase < 9; phase++) begin
      if (phase < 3) begin
        send_idle_pct = 33;
        recv_idle_pct = 87;
      end else if (phase < 6) begin
        send_idle_pct = 87;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_depth(depth_plan[phase]);
      for (n = 0; n < LINES_PER_DEPTH; n++) begin
        send_line(random_line());
      end
      drain_lines();
    end

    if (book.mismatches == 0) begin
      $display("tb_luma_edge_deblock_filter passed");
    end else begin
      $display("tb_luma_edge_deblock_filter failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/led_pkg.sv
design/led_if.sv
design/led_decide.sv
design/led_filter.sv
design/luma_edge_deblock_filter.sv
design/led_checker.sv
dv/tb_luma_edge_deblock_filter.sv
